@@ hdl/mcst_pkg.sv @@
// ----------------------------------------------------------------------------
// mcst_pkg
// Shared types and constants for the multi-channel soft timer: channel count,
// request mode codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package mcst_pkg;

    // Number of timer channels in the bank.
    localparam int CHANNELS = 8;

    // Index width for the channel stores, and width of the scan counter, which
    // must also hold CHANNELS itself.
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SCNT_W   = $clog2(CHANNELS + 1);

    // Fixed field widths of the request and result payloads.
    localparam int MODE_W  = 2;
    localparam int CHAN_W  = 3;
    localparam int IVL_W   = 32;
    localparam int TIME_W  = 64;

    // Request mode codes. The remaining code is ignored.
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } mcst_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                tick;
        logic                start;
        logic                stop;
        logic                rd_en;
        logic [CH_IDX_W-1:0] rd_addr;
        logic                emit_en;
    } mcst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mask_empty;
    } mcst_sts_t;

endpackage

@@ hdl/mcst_channel_if.sv @@
// ----------------------------------------------------------------------------
// mcst_channel_if
// Valid/ready channels of the soft timer: the request channel and the
// fired-channel result channel.
// ----------------------------------------------------------------------------
interface mcst_req_if;
    logic                          valid;
    logic                          ready;
    logic [mcst_pkg::MODE_W-1:0]   mode;
    logic [mcst_pkg::CHAN_W-1:0]   channel;
    logic [mcst_pkg::IVL_W-1:0]    interval_ms;
    logic                          single_shot;

    modport source (output valid, mode, channel, interval_ms, single_shot, input ready);
    modport sink   (input valid, mode, channel, interval_ms, single_shot, output ready);
endinterface

interface mcst_fired_if;
    logic                          valid;
    logic                          ready;
    logic [mcst_pkg::CHAN_W-1:0]   fired_channel;
    logic                          last;

    modport source (output valid, fired_channel, last, input ready);
    modport sink   (input valid, fired_channel, last, output ready);
endinterface

@@ hdl/multi_channel_soft_timer_top.sv @@
// ----------------------------------------------------------------------------
// multi_channel_soft_timer_top
// Bank of periodic and one-shot timer channels advanced by a millisecond tick.
// Each tick scans the channels in ascending order and reports fired channels.
//
//   Channel  Direction  Payload
//   req      in         mode, channel, interval_ms, single_shot
//   fired    out        fired_channel, last
//
// A start or stop request takes effect as it is accepted. An accepted tick
// starts the scan: one channel read per cycle from the period and due-time
// memories into the read stage, then a compare and reschedule in the check
// stage; then one fired channel is handed on per cycle while results are
// taken, and the controller returns to idle; a stalled result output holds
// the drain. Requests are accepted only between ticks' scans and drains.
// After reset all channels are disarmed and the time counter is zero; the
// memories need no clearing pass.
// ----------------------------------------------------------------------------
module multi_channel_soft_timer_top (
    input  logic         clk,
    input  logic         rst_n,
    mcst_req_if.sink     req,
    mcst_fired_if.source fired
);

    mcst_pkg::mcst_cmd_t cmd;
    mcst_pkg::mcst_sts_t sts;

    // Request sequencing.
    mcst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_mode  (req.mode),
        .req_ready (req.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Channel state and result output.
    mcst_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .channel     (req.channel),
        .interval_ms (req.interval_ms),
        .single_shot (req.single_shot),
        .fired       (fired)
    );

endmodule

@@ hdl/mcst_ctrl.sv @@
// ----------------------------------------------------------------------------
// mcst_ctrl
// Controller of the soft timer. Accepts requests while idle, sequences the
// channel scan after a tick and then lets the datapath drain fired channels.
// ----------------------------------------------------------------------------
module mcst_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [mcst_pkg::MODE_W-1:0] req_mode,
    output logic                        req_ready,
    output mcst_pkg::mcst_cmd_t         cmd,
    input  mcst_pkg::mcst_sts_t         sts
);

    mcst_pkg::mcst_state_t             state_reg, state_next;
    logic [mcst_pkg::SCNT_W-1:0]       cnt_reg, cnt_next;
    logic                              accept;
    logic                              scan_done;

    assign accept    = req_valid && req_ready;
    assign scan_done = (cnt_reg == mcst_pkg::SCNT_W'(mcst_pkg::CHANNELS));

    // State and scan counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mcst_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and next scan count.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            mcst_pkg::ST_IDLE:
            begin
                if (accept && req_mode == mcst_pkg::MODE_TICK)
                begin
                    state_next = mcst_pkg::ST_SCAN;
                    cnt_next   = '0;
                end
            end
            mcst_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = mcst_pkg::ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            mcst_pkg::ST_EMIT:
            begin
                if (sts.mask_empty)
                begin
                    state_next = mcst_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mcst_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and datapath commands.
    always_comb
    begin
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.rd_addr = cnt_reg[mcst_pkg::CH_IDX_W-1:0];
        unique case (state_reg)
            mcst_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.tick  = req_valid && req_mode == mcst_pkg::MODE_TICK;
                cmd.start = req_valid && req_mode == mcst_pkg::MODE_START;
                cmd.stop  = req_valid && req_mode == mcst_pkg::MODE_STOP;
            end
            mcst_pkg::ST_SCAN:
            begin
                cmd.rd_en = !scan_done;
            end
            mcst_pkg::ST_EMIT:
            begin
                cmd.emit_en = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // Idle is reached only after every fired channel has been handed on.
    a_idle_mask_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mcst_pkg::ST_IDLE) |-> sts.mask_empty)
        else $error("mcst_ctrl: idle with fired channels pending");

    // The scan counter never runs past the channel count.
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= mcst_pkg::SCNT_W'(mcst_pkg::CHANNELS))
        else $error("mcst_ctrl: scan counter out of range");

    // An accepted tick starts a scan from the first channel.
    a_tick_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_mode == mcst_pkg::MODE_TICK)
        |=> (state_reg == mcst_pkg::ST_SCAN && cnt_reg == '0))
        else $error("mcst_ctrl: tick did not start a scan");
`endif

endmodule

@@ hdl/mcst_dp.sv @@
// ----------------------------------------------------------------------------
// mcst_dp
// Datapath of the soft timer: time counter, armed and one-shot flags, the
// period and due-time memories, the scan compare/reschedule stage, the fired
// channel mask and the result output register.
// ----------------------------------------------------------------------------
module mcst_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mcst_pkg::mcst_cmd_t          cmd,
    output mcst_pkg::mcst_sts_t          sts,
    input  logic [mcst_pkg::CHAN_W-1:0]  channel,
    input  logic [mcst_pkg::IVL_W-1:0]   interval_ms,
    input  logic                         single_shot,
    mcst_fired_if.source                 fired
);

    localparam int N = mcst_pkg::CHANNELS;

    // Channel stores.
    logic [mcst_pkg::IVL_W-1:0]   period_mem [N];
    logic [mcst_pkg::TIME_W-1:0]  due_mem    [N];

    logic [mcst_pkg::TIME_W-1:0]  now_reg;
    logic [N-1:0]                 armed_reg, armed_next;
    logic [N-1:0]                 one_shot_reg, one_shot_next;
    logic [N-1:0]                 mask_reg, mask_next;

    // Read stage and check stage.
    logic [mcst_pkg::TIME_W-1:0]  due_rd_reg;
    logic [mcst_pkg::IVL_W-1:0]   per_rd_reg;
    logic                         chk_valid_reg;
    logic [mcst_pkg::CH_IDX_W-1:0] chk_idx_reg;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [mcst_pkg::CHAN_W-1:0]  out_chan_reg;
    logic                         out_last_reg;

    logic                         start_ok;
    logic                         stop_ok;
    logic [mcst_pkg::CH_IDX_W-1:0] req_idx;
    logic                         fire;
    logic                         mem_we;
    logic [mcst_pkg::CH_IDX_W-1:0] mem_waddr;
    logic [mcst_pkg::TIME_W-1:0]  due_wdata;
    logic [N-1:0]                 pick_oh;
    logic [mcst_pkg::CH_IDX_W-1:0] pick_idx;
    logic                         load;

    // Request decode: out-of-bank starts and stops and zero-interval starts are dropped.
    assign req_idx  = mcst_pkg::CH_IDX_W'(channel);
    assign stop_ok  = cmd.stop && (32'(channel) < 32'(N));
    assign start_ok = cmd.start && (32'(channel) < 32'(N)) && (interval_ms != '0);

    // An armed channel whose due time has been reached fires.
    assign fire = chk_valid_reg && armed_reg[chk_idx_reg] && !(due_rd_reg > now_reg);

    // Memory write port, shared by start (idle) and reschedule (scan).
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = chk_idx_reg;
        due_wdata = now_reg + mcst_pkg::TIME_W'(per_rd_reg);
        if (start_ok)
        begin
            mem_we    = 1'b1;
            mem_waddr = req_idx;
            due_wdata = now_reg + mcst_pkg::TIME_W'(interval_ms);
        end
        else if (fire)
        begin
            mem_we = 1'b1;
        end
    end

    // Period and due-time memories with registered reads.
    always_ff @(posedge clk)
    begin
        if (start_ok)
        begin
            period_mem[req_idx] <= interval_ms;
        end
        if (mem_we)
        begin
            due_mem[mem_waddr] <= due_wdata;
        end
        if (cmd.rd_en)
        begin
            due_rd_reg <= due_mem[cmd.rd_addr];
            per_rd_reg <= period_mem[cmd.rd_addr];
        end
    end

    // Lowest pending fired channel.
    always_comb
    begin
        pick_idx = '0;
        pick_oh  = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_idx = mcst_pkg::CH_IDX_W'(i);
            end
        end
        pick_oh[pick_idx] = (mask_reg != '0);
    end

    assign load = cmd.emit_en && (mask_reg != '0) && (!out_valid_reg || fired.ready);

    // Flag and mask updates.
    always_comb
    begin
        armed_next    = armed_reg;
        one_shot_next = one_shot_reg;
        mask_next     = mask_reg;
        if (start_ok)
        begin
            armed_next[req_idx]    = 1'b1;
            one_shot_next[req_idx] = single_shot;
        end
        if (stop_ok)
        begin
            armed_next[req_idx] = 1'b0;
        end
        if (fire)
        begin
            mask_next[chk_idx_reg] = 1'b1;
            if (one_shot_reg[chk_idx_reg])
            begin
                armed_next[chk_idx_reg] = 1'b0;
            end
        end
        if (load)
        begin
            mask_next = mask_reg & ~pick_oh;
        end
    end

    // Output valid: set on load, cleared once the result is taken.
    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (fired.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg       <= '0;
            armed_reg     <= '0;
            one_shot_reg  <= '0;
            mask_reg      <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.tick)
            begin
                now_reg <= now_reg + 1'b1;
            end
            armed_reg     <= armed_next;
            one_shot_reg  <= one_shot_next;
            mask_reg      <= mask_next;
            chk_valid_reg <= cmd.rd_en;
            chk_idx_reg   <= cmd.rd_addr;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload; last is set when no other fired channel remains.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_chan_reg <= mcst_pkg::CHAN_W'(pick_idx);
            out_last_reg <= ((mask_reg & ~pick_oh) == '0);
        end
    end

    assign fired.valid         = out_valid_reg;
    assign fired.fired_channel = out_chan_reg;
    assign fired.last          = out_last_reg;
    assign sts.mask_empty      = (mask_reg == '0);

`ifndef ASSERT_OFF
    // A firing channel is recorded as pending.
    a_fire_mask: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> mask_reg[$past(chk_idx_reg)])
        else $error("mcst_dp: fired channel not recorded");

    // A channel handed to the output is removed from the pending mask.
    a_load_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> !mask_reg[$past(pick_idx)])
        else $error("mcst_dp: emitted channel still pending");

    // Start writes and scan reschedules never collide on the memory port.
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(start_ok && chk_valid_reg))
        else $error("mcst_dp: start during scan");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-channel soft timer. A directed table covers
// the timer's corner cases, then random tick, start, stop and unused requests
// follow. Each accepted request steps a timer bank model; each fired result is
// checked in order against the table's fire mask where given, else against
// the model's prediction. Both handshake sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import mcst_pkg::*;

    // The one request mode that the block ignores.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 326;
    localparam int PAUSE_AT        = 175;
    localparam int IDLE_LIMIT      = 400;
    localparam int DRAIN_CYCLES    = CHANNELS + 8;
    localparam int DIRECTED_ROWS   = 24;

    // One expected fired-channel result.
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              last;
    } fire_t;

    // One row of the directed table. Where has_mask is set, fire_mask gives
    // the channels that must fire; otherwise the timer model decides.
    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [CHAN_W-1:0]   channel;
        logic [IVL_W-1:0]    interval_ms;
        logic                single_shot;
        logic                has_mask;
        logic [CHANNELS-1:0] fire_mask;
    } timer_row_t;

    logic clk = 1'b0;
    logic rst_n;

    mcst_req_if   req ();
    mcst_fired_if fired ();

    multi_channel_soft_timer_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .fired (fired)
    );

    always #4 clk = ~clk;

    // Timer bank model state.
    logic [TIME_W-1:0] tick_count;
    bit                ch_armed  [CHANNELS];
    bit                ch_once   [CHANNELS];
    logic [IVL_W-1:0]  ch_period [CHANNELS];
    logic [TIME_W-1:0] ch_expiry [CHANNELS];

    fire_t pending_fires [$];
    int    mismatches = 0;
    int    idle_cycles = 0;
    bit    burst = 1'b0;

    // Directed requests: ignored requests, a one-shot, every channel firing on
    // one tick, a restart of an armed channel and stops of idle and armed ones.
    timer_row_t timer_rows [DIRECTED_ROWS] = '{
        // Tick straight after reset: nothing is armed.
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        // Unused mode with every other field at its top value.
        '{MODE_UNUSED, 3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'h00},
        // Start with a zero interval is ignored.
        '{MODE_START,  3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        // Stop of a channel that is not running.
        '{MODE_STOP,   3'd5, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        // One-shot fires once, then stays quiet.
        '{MODE_START,  3'd0, 32'h0000_0001, 1'b1, 1'b1, 8'h00},
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h01},
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        // Longest interval, later replaced by a restart.
        '{MODE_START,  3'd7, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd1, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd2, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd3, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd4, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd5, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd6, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd0, 32'h0000_0001, 1'b0, 1'b1, 8'h00},
        '{MODE_START,  3'd7, 32'h0000_0001, 1'b1, 1'b1, 8'h00},
        // All eight channels fire on the same tick.
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'hFF},
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h7F},
        '{MODE_STOP,   3'd1, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        '{MODE_STOP,   3'd3, 32'h0000_0000, 1'b0, 1'b1, 8'h00},
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b1, 8'h75},
        '{MODE_START,  3'd2, 32'h0000_0003, 1'b1, 1'b0, 8'h00},
        '{MODE_TICK,   3'd0, 32'h0000_0000, 1'b0, 1'b0, 8'h00}
    };

    // Step the timer bank by one request and return the channels that fire.
    function automatic logic [CHANNELS-1:0] advance_timers(
        input logic [MODE_W-1:0] mode,
        input logic [CHAN_W-1:0] channel,
        input logic [IVL_W-1:0]  interval_ms,
        input logic              single_shot
    );
        logic [CHANNELS-1:0] hits;
        hits = '0;
        case (mode)
            MODE_TICK:
            begin
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (ch_armed[i] && ch_expiry[i] <= tick_count)
                    begin
                        // Rescheduled from the current time, so lateness drifts.
                        ch_expiry[i] = tick_count + TIME_W'(ch_period[i]);
                        if (ch_once[i])
                            ch_armed[i] = 1'b0;
                        hits[i] = 1'b1;
                    end
                end
            end
            MODE_START:
            begin
                if (int'(channel) < CHANNELS && interval_ms != '0)
                begin
                    ch_armed[channel]  = 1'b1;
                    ch_once[channel]   = single_shot;
                    ch_period[channel] = interval_ms;
                    ch_expiry[channel] = tick_count + TIME_W'(interval_ms);
                end
            end
            MODE_STOP:
            begin
                if (int'(channel) < CHANNELS)
                    ch_armed[channel] = 1'b0;
            end
            default:
            begin
            end
        endcase
        return hits;
    endfunction

    // Queue the results of one tick: fired channels in ascending order, the
    // highest one marked last.
    function automatic void queue_fires(input logic [CHANNELS-1:0] hits);
        fire_t entry;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (hits[i])
            begin
                entry.channel = CHAN_W'(i);
                entry.last    = ((hits >> (i + 1)) == '0);
                pending_fires.push_back(entry);
            end
        end
    endfunction

    // Drive one request after a random gap and account for it once accepted.
    task automatic send_request(
        input logic [MODE_W-1:0]   mode,
        input logic [CHAN_W-1:0]   channel,
        input logic [IVL_W-1:0]    interval_ms,
        input logic                single_shot,
        input logic                has_mask,
        input logic [CHANNELS-1:0] fire_mask
    );
        int                  gap;
        logic [CHANNELS-1:0] hits;
        gap = burst ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            @(negedge clk);
            req.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req.valid       <= 1'b1;
        req.mode        <= mode;
        req.channel     <= channel;
        req.interval_ms <= interval_ms;
        req.single_shot <= single_shot;
        do
            @(posedge clk);
        while (!req.ready);
        hits = advance_timers(mode, channel, interval_ms, single_shot);
        queue_fires(has_mask ? fire_mask : hits);
    endtask

    // Result side: random stalls, then check each accepted result in order.
    initial
    begin
        int    stall;
        fire_t want;
        fired.ready = 1'b0;
        forever
        begin
            stall = burst ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                @(negedge clk);
                fired.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            fired.ready <= 1'b1;
            do
                @(posedge clk);
            while (!fired.valid);
            if (pending_fires.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got channel %0d last %0b",
                         $time, fired.fired_channel, fired.last);
            end
            else
            begin
                want = pending_fires.pop_front();
                if (fired.fired_channel !== want.channel)
                begin
                    mismatches++;
                    $display("%0t: fired_channel mismatch: expected %0d, got %0d",
                             $time, want.channel, fired.fired_channel);
                end
                if (fired.last !== want.last)
                begin
                    mismatches++;
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.last, fired.last);
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block is stuck.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (fired.valid && fired.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    // Reset, directed table, random requests, then drain.
    initial
    begin
        int                count;
        int                pick;
        int                span;
        bit                paused;
        logic [MODE_W-1:0] mode;
        logic [IVL_W-1:0]  interval_ms;

        rst_n           = 1'b0;
        req.valid       = 1'b0;
        req.mode        = MODE_TICK;
        req.channel     = '0;
        req.interval_ms = '0;
        req.single_shot = 1'b0;
        tick_count      = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_armed[i]  = 1'b0;
            ch_once[i]   = 1'b0;
            ch_period[i] = '0;
            ch_expiry[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_request(timer_rows[r].mode, timer_rows[r].channel,
                         timer_rows[r].interval_ms, timer_rows[r].single_shot,
                         timer_rows[r].has_mask, timer_rows[r].fire_mask);

        // Mostly ticks and short-interval starts so that channels keep firing.
        count  = 0;
        paused = 1'b0;
        while (count < RANDOM_REQUESTS)
        begin
            if (count % 40 == 0)
                burst = ($urandom_range(0, 3) == 0);
            // Hold the requests back once until every result has been taken.
            if (count == PAUSE_AT && !paused)
            begin
                @(negedge clk);
                req.valid <= 1'b0;
                while (pending_fires.size() != 0)
                    @(negedge clk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
                mode = MODE_TICK;
            else if (pick < 80)
                mode = MODE_START;
            else if (pick < 95)
                mode = MODE_STOP;
            else
                mode = MODE_UNUSED;
            span = $urandom_range(0, 19);
            if (span < 13)
                interval_ms = $urandom_range(1, 8);
            else if (span < 16)
                interval_ms = $urandom_range(9, 40);
            else if (span < 19)
                interval_ms = $urandom;
            else
                interval_ms = '0;
            send_request(mode, CHAN_W'($urandom_range(0, 7)), interval_ms,
                         1'($urandom_range(0, 1)), 1'b0, '0);
            count++;
        end
        @(negedge clk);
        req.valid <= 1'b0;
        burst = 1'b0;

        while (pending_fires.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/mcst_pkg.sv
hdl/mcst_channel_if.sv
hdl/mcst_ctrl.sv
hdl/mcst_dp.sv
hdl/multi_channel_soft_timer_top.sv
bench/tb_top.sv
